// ===== design/lru_timestamp_context_cache_macros.svh =====
// Assertion macros for the LRU timestamp context cache checker.
// No dependencies; the including module must provide clk and rst_n.
`ifndef LRU_TIMESTAMP_CONTEXT_CACHE_MACROS_SVH
`define LRU_TIMESTAMP_CONTEXT_CACHE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lts_pkg.sv =====
// Shared types and constants for the LRU timestamp context cache.
// No dependencies; used by every module of the block.
package lts_pkg;

  // Default number of built table entries.
  localparam int unsigned TABLE_DEPTH_DEF = 64;

  // Field widths fixed by the interface.
  localparam int unsigned KEY_W        = 64;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned HANDLE_W     = 32;
  localparam int unsigned REUSE_W      = 32;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned SLOT_W       = 7;
  localparam int unsigned OUT_IDX_W    = 6;
  localparam int unsigned TABLE_SIZE_W = 7;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_TABLE_SIZE = '0;
  localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RST = TABLE_SIZE_W'(64);

  // Request modes.
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  // One stored table row.
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   stamp;
    logic [REUSE_W-1:0]  reuse;
  } entry_t;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  // Status from the scan unit back to the sequencer.
  typedef struct packed {
    logic match;
    logic have_cand;
  } scan_sts_t;

endpackage

// ===== design/lru_timestamp_context_cache.sv =====
// Top level of the LRU timestamp context cache: sequencer, counters, config port.
// Depends on lts_pkg, lts_entry_ram and lts_scan.
//
//   channel | direction | handshake          | content
//   in_     | request   | in_valid/in_ready  | mode, key, now_time, slot_index, handle
//   out_    | result    | out_valid/out_ready| hit, indexes, handle, flags, totals
//   cfg     | APB write | psel/penable/pready| table_size at byte address 0
//
// Rows stream from the entry memory one per cycle through its registered read port.
// A lookup reads rows in order until the first match or until min(fill, size) rows
// are read, and skips the scan when no row is filled; an insert reads no rows.
// The memory is written in the final cycle, before the next request is taken.
// A result still waiting on the output holds the next request in its final cycle.
// Reset leaves the memory as is: rows at or beyond the fill count are never scanned.
module lru_timestamp_context_cache #(
  parameter int unsigned TABLE_DEPTH = lts_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Request channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_mode,
  input  logic [lts_pkg::KEY_W-1:0]           in_key,
  input  logic [lts_pkg::TIME_W-1:0]          in_now_time,
  input  logic [lts_pkg::SLOT_W-1:0]          in_slot_index,
  input  logic [lts_pkg::HANDLE_W-1:0]        in_payload_handle,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_hit,
  output logic [lts_pkg::OUT_IDX_W-1:0]       out_found_index,
  output logic [lts_pkg::OUT_IDX_W-1:0]       out_insert_index,
  output logic [lts_pkg::HANDLE_W-1:0]        out_stored_handle,
  output logic                                out_insert_error,
  output logic                                out_evicted,
  output logic [lts_pkg::COUNT_W-1:0]         out_hit_total,
  output logic [lts_pkg::COUNT_W-1:0]         out_miss_total,
  output logic [lts_pkg::COUNT_W-1:0]         out_purge_total,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lts_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [lts_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [lts_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned SZ_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CNT_W = (SZ_W > lts_pkg::TABLE_SIZE_W) ? SZ_W
                                                                 : lts_pkg::TABLE_SIZE_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Control state.
  logic [1:0]                         state_r, state_nxt;
  logic                               rd_vld_r, rd_vld_nxt;
  logic                               fhit_r, fhit_nxt;
  logic [CNT_W-1:0]                   fill_r, fill_nxt;
  logic [lts_pkg::COUNT_W-1:0]        hit_cnt_r, hit_cnt_nxt;
  logic [lts_pkg::COUNT_W-1:0]        miss_cnt_r, miss_cnt_nxt;
  logic [lts_pkg::COUNT_W-1:0]        purge_cnt_r, purge_cnt_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [lts_pkg::TABLE_SIZE_W-1:0]   table_size_r;

  // Request and scan payload.
  logic                               mode_r;
  logic [lts_pkg::KEY_W-1:0]          key_r;
  logic [lts_pkg::TIME_W-1:0]         now_r;
  logic [lts_pkg::SLOT_W-1:0]         slot_r;
  logic [lts_pkg::HANDLE_W-1:0]       handle_r;
  logic [CNT_W-1:0]                   limit_r, limit_nxt;
  logic [CNT_W-1:0]                   iss_r, iss_nxt;
  logic [IDX_W-1:0]                   rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]                   found_r, found_nxt;
  logic [lts_pkg::HANDLE_W-1:0]       hit_handle_r, hit_handle_nxt;
  logic [lts_pkg::REUSE_W-1:0]        hit_reuse_r, hit_reuse_nxt;

  // Result register.
  logic                               out_hit_r, out_hit_nxt;
  logic [lts_pkg::OUT_IDX_W-1:0]      out_found_r, out_found_nxt;
  logic [lts_pkg::OUT_IDX_W-1:0]      out_ins_r, out_ins_nxt;
  logic [lts_pkg::HANDLE_W-1:0]       out_handle_r, out_handle_nxt;
  logic                               out_err_r, out_err_nxt;
  logic                               out_evict_r, out_evict_nxt;

  // Memory and scan wiring.
  logic                               wr_en;
  logic [IDX_W-1:0]                   wr_addr;
  lts_pkg::entry_t                    wr_row;
  lts_pkg::entry_t                    rd_row;
  lts_pkg::scan_ctl_t                 scan_ctl;
  lts_pkg::scan_sts_t                 scan_sts;
  logic [IDX_W-1:0]                   cand_idx;

  // Misc decode.
  logic                               in_fire;
  logic                               cfg_wr;
  logic [CNT_W-1:0]                   ts_ext;
  logic [CNT_W-1:0]                   size_eff;
  logic [CNT_W-1:0]                   fill_lim;
  logic [CNT_W-1:0]                   slot_ext;
  logic                               slot_bad;
  logic                               append;
  logic                               rd_last;
  logic                               out_free;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // Effective table size: zero acts as one, values past the built depth clamp.
  assign ts_ext = CNT_W'(table_size_r);
  always_comb begin
    if (table_size_r == '0) begin
      size_eff = ONE_C;
    end else if (ts_ext > DEPTH_C) begin
      size_eff = DEPTH_C;
    end else begin
      size_eff = ts_ext;
    end
  end

  assign fill_lim = (fill_r < size_eff) ? fill_r : size_eff;
  assign slot_ext = CNT_W'(slot_r);
  assign slot_bad = slot_ext >= size_eff;
  assign append   = (slot_ext == fill_r) && (fill_r < size_eff);
  assign rd_last  = (CNT_W'(rd_idx_r) + ONE_C) == limit_r;

  // Configuration register: table_size at word 0, written in the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[lts_pkg::CFG_ADDR_W-1:2] == lts_pkg::REG_TABLE_SIZE);
  assign prdata = (paddr[lts_pkg::CFG_ADDR_W-1:2] == lts_pkg::REG_TABLE_SIZE)
                  ? lts_pkg::CFG_DATA_W'(table_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= lts_pkg::TABLE_SIZE_RST;
    end else if (cfg_wr) begin
      table_size_r <= pwdata[lts_pkg::TABLE_SIZE_W-1:0];
    end
  end

  // Scan unit control: clear on a new request, step on each returned row.
  assign scan_ctl.clear = in_fire;
  assign scan_ctl.step  = (state_r == ST_SCAN) && rd_vld_r;

  // Sequencer: accept, stream rows, then finish with any write-back and the result.
  always_comb begin
    state_nxt      = state_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    iss_nxt        = iss_r;
    limit_nxt      = limit_r;
    fhit_nxt       = fhit_r;
    found_nxt      = found_r;
    hit_handle_nxt = hit_handle_r;
    hit_reuse_nxt  = hit_reuse_r;
    fill_nxt       = fill_r;
    hit_cnt_nxt    = hit_cnt_r;
    miss_cnt_nxt   = miss_cnt_r;
    purge_cnt_nxt  = purge_cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_hit_nxt    = out_hit_r;
    out_found_nxt  = out_found_r;
    out_ins_nxt    = out_ins_r;
    out_handle_nxt = out_handle_r;
    out_err_nxt    = out_err_r;
    out_evict_nxt  = out_evict_r;
    wr_en          = 1'b0;
    wr_addr        = found_r;
    wr_row         = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          fhit_nxt  = 1'b0;
          limit_nxt = fill_lim;
          iss_nxt   = '0;
          if ((in_mode == lts_pkg::MODE_INSERT) || (fill_lim == '0)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue the next row read while rows remain.
        if (iss_r < limit_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = iss_r[IDX_W-1:0];
          iss_nxt    = iss_r + ONE_C;
        end
        // Check the row that returned this cycle.
        if (rd_vld_r) begin
          if (scan_sts.match) begin
            fhit_nxt       = 1'b1;
            found_nxt      = rd_idx_r;
            hit_handle_nxt = rd_row.handle;
            hit_reuse_nxt  = rd_row.reuse;
            rd_vld_nxt     = 1'b0;
            state_nxt      = ST_DONE;
          end else if (rd_last) begin
            rd_vld_nxt = 1'b0;
            state_nxt  = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_hit_nxt    = 1'b0;
          out_found_nxt  = '0;
          out_ins_nxt    = '0;
          out_handle_nxt = '0;
          out_err_nxt    = 1'b0;
          out_evict_nxt  = 1'b0;
          state_nxt      = ST_IDLE;
          if (mode_r == lts_pkg::MODE_INSERT) begin
            if (slot_bad) begin
              out_err_nxt = 1'b1;
            end else begin
              // New row: reuse count restarts at zero.
              wr_en           = 1'b1;
              wr_addr         = IDX_W'(slot_r);
              wr_row.key      = key_r;
              wr_row.handle   = handle_r;
              wr_row.stamp    = now_r;
              wr_row.reuse    = '0;
              miss_cnt_nxt    = miss_cnt_r + lts_pkg::COUNT_W'(1);
              if (append) begin
                fill_nxt = fill_r + ONE_C;
              end else begin
                purge_cnt_nxt = purge_cnt_r + lts_pkg::COUNT_W'(1);
                out_evict_nxt = 1'b1;
              end
            end
          end else if (fhit_r) begin
            // Hit: refresh the stamp and bump the reuse count of the row.
            wr_en           = 1'b1;
            wr_addr         = found_r;
            wr_row.key      = key_r;
            wr_row.handle   = hit_handle_r;
            wr_row.stamp    = now_r;
            wr_row.reuse    = hit_reuse_r + lts_pkg::REUSE_W'(1);
            hit_cnt_nxt     = hit_cnt_r + lts_pkg::COUNT_W'(1);
            out_hit_nxt     = 1'b1;
            out_found_nxt   = lts_pkg::OUT_IDX_W'(found_r);
            out_handle_nxt  = hit_handle_r;
          end else if (fill_r >= size_eff) begin
            out_ins_nxt = scan_sts.have_cand ? lts_pkg::OUT_IDX_W'(cand_idx) : '0;
          end else begin
            out_ins_nxt = lts_pkg::OUT_IDX_W'(fill_r);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      fhit_r      <= 1'b0;
      fill_r      <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      purge_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      fhit_r      <= fhit_nxt;
      fill_r      <= fill_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      purge_cnt_r <= purge_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r   <= in_mode;
      key_r    <= in_key;
      now_r    <= in_now_time;
      slot_r   <= in_slot_index;
      handle_r <= in_payload_handle;
    end
    limit_r      <= limit_nxt;
    iss_r        <= iss_nxt;
    rd_idx_r     <= rd_idx_nxt;
    found_r      <= found_nxt;
    hit_handle_r <= hit_handle_nxt;
    hit_reuse_r  <= hit_reuse_nxt;
    out_hit_r    <= out_hit_nxt;
    out_found_r  <= out_found_nxt;
    out_ins_r    <= out_ins_nxt;
    out_handle_r <= out_handle_nxt;
    out_err_r    <= out_err_nxt;
    out_evict_r  <= out_evict_nxt;
  end

  // Entry memory.
  lts_entry_ram #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_row   (wr_row),
    .rd_addr  (iss_r[IDX_W-1:0]),
    .rd_row_r (rd_row)
  );

  // Key compare and LRU candidate tracking.
  lts_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .clear_time (in_now_time),
    .key        (key_r),
    .row_idx    (rd_idx_r),
    .row        (rd_row),
    .sts        (scan_sts),
    .cand_idx   (cand_idx)
  );

  // Result outputs; totals are the counters after the reported request.
  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_found_index   = out_found_r;
  assign out_insert_index  = out_ins_r;
  assign out_stored_handle = out_handle_r;
  assign out_insert_error  = out_err_r;
  assign out_evicted       = out_evict_r;
  assign out_hit_total     = hit_cnt_r;
  assign out_miss_total    = miss_cnt_r;
  assign out_purge_total   = purge_cnt_r;

endmodule

// ===== design/lts_entry_ram.sv =====
// Entry memory of the LRU timestamp context cache: one write, one read port.
// Depends on lts_pkg for the row type.
module lts_entry_ram #(
  parameter int unsigned TABLE_DEPTH = lts_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned IDX_W       = $clog2(lts_pkg::TABLE_DEPTH_DEF)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  lts_pkg::entry_t     wr_row,
  input  logic [IDX_W-1:0]    rd_addr,
  output lts_pkg::entry_t     rd_row_r
);

  lts_pkg::entry_t mem [TABLE_DEPTH];

  // Synchronous write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    rd_row_r <= mem[rd_addr];
  end

endmodule

// ===== design/lts_scan.sv =====
// Scan unit: compares each streamed row with the key and tracks the LRU candidate.
// Depends on lts_pkg for the row and control types.
module lts_scan #(
  parameter int unsigned IDX_W = $clog2(lts_pkg::TABLE_DEPTH_DEF)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lts_pkg::scan_ctl_t            ctl,
  input  logic [lts_pkg::TIME_W-1:0]    clear_time,
  input  logic [lts_pkg::KEY_W-1:0]     key,
  input  logic [IDX_W-1:0]              row_idx,
  input  lts_pkg::entry_t               row,
  output lts_pkg::scan_sts_t            sts,
  output logic [IDX_W-1:0]              cand_idx
);

  logic [lts_pkg::TIME_W-1:0] oldest_r;
  logic [IDX_W-1:0]           cand_r;
  logic                       have_r;
  logic                       older;

  // A row is a better candidate only when strictly older than the best so far.
  assign older = row.stamp < oldest_r;

  // The running minimum starts at the request's time, so only rows used earlier count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (ctl.clear) begin
      have_r <= 1'b0;
    end else if (ctl.step && older) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      oldest_r <= clear_time;
      cand_r   <= '0;
    end else if (ctl.step && older) begin
      oldest_r <= row.stamp;
      cand_r   <= row_idx;
    end
  end

  assign sts.match     = ctl.step && (row.key == key);
  assign sts.have_cand = have_r;
  assign cand_idx      = cand_r;

endmodule

// ===== design/lts_port_checker.sv =====
// Port-level checker for the LRU timestamp context cache, bound to the top level.
// Depends on lts_pkg and lru_timestamp_context_cache_macros.svh.
`include "lru_timestamp_context_cache_macros.svh"

module lts_port_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                out_hit,
  input logic [lts_pkg::OUT_IDX_W-1:0]       out_found_index,
  input logic [lts_pkg::OUT_IDX_W-1:0]       out_insert_index,
  input logic [lts_pkg::HANDLE_W-1:0]        out_stored_handle,
  input logic                                out_insert_error,
  input logic                                out_evicted,
  input logic [lts_pkg::COUNT_W-1:0]         out_hit_total
);

  // A stalled result keeps its payload.
  `LTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_found_index) && $stable(out_hit_total) &&
                   $stable(out_stored_handle), "result changed while stalled")

  // One request at a time: the block is busy right after taking one.
  `LTS_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready,
                   "request taken while busy")

  // A hit carries no insert slot and no insert flags.
  `LTS_ASSERT_NOW(a_hit_clean, out_valid && out_hit,
                  !out_insert_error && !out_evicted && (out_insert_index == '0),
                  "hit result carries insert fields")

  // A rejected insert neither hits nor evicts.
  `LTS_ASSERT_NOW(a_err_clean, out_valid && out_insert_error,
                  !out_hit && !out_evicted && (out_stored_handle == '0),
                  "error result carries other flags")

endmodule

bind lru_timestamp_context_cache lts_port_checker u_lts_port_checker (.*);

// ===== tb/sv/lru_timestamp_context_cache_tb.sv =====
// Self-checking testbench for the LRU timestamp context cache: directed and random requests.
// Depends on lts_pkg and lru_timestamp_context_cache; predicts every result in-house.
module lru_timestamp_context_cache_tb;
  import lts_pkg::*;

  localparam int unsigned DEPTH = TABLE_DEPTH_DEF;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam logic [CFG_ADDR_W-1:0] TABLE_SIZE_ADDR = CFG_ADDR_W'(4 * REG_TABLE_SIZE);

  typedef struct {
    logic                  mode;
    logic [KEY_W-1:0]      key;
    logic [TIME_W-1:0]     now;
    logic [SLOT_W-1:0]     slot;
    logic [HANDLE_W-1:0]   handle;
  } cache_req_t;

  typedef struct {
    logic                  hit;
    logic [OUT_IDX_W-1:0]  found_index;
    logic [OUT_IDX_W-1:0]  insert_index;
    logic [HANDLE_W-1:0]   stored_handle;
    logic                  insert_error;
    logic                  evicted;
    logic [COUNT_W-1:0]    hit_total;
    logic [COUNT_W-1:0]    miss_total;
    logic [COUNT_W-1:0]    purge_total;
  } cache_resp_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, in_mode;
  logic [KEY_W-1:0] in_key;
  logic [TIME_W-1:0] in_now_time;
  logic [SLOT_W-1:0] in_slot_index;
  logic [HANDLE_W-1:0] in_payload_handle;
  logic out_valid, out_ready, out_hit, out_insert_error, out_evicted;
  logic [OUT_IDX_W-1:0] out_found_index, out_insert_index;
  logic [HANDLE_W-1:0] out_stored_handle;
  logic [COUNT_W-1:0] out_hit_total, out_miss_total, out_purge_total;
  logic psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;

  // Shadow copy of the table, the counters and the size register.
  logic [KEY_W-1:0]    tbl_key      [DEPTH];
  logic [HANDLE_W-1:0] tbl_handle   [DEPTH];
  logic [TIME_W-1:0]   tbl_stamp    [DEPTH];
  logic [REUSE_W-1:0]  tbl_reuse    [DEPTH];
  int unsigned         tbl_fill;
  logic [COUNT_W-1:0]  hits_seen, misses_seen, purges_seen;
  logic [TABLE_SIZE_W-1:0] size_reg;

  cache_resp_t pending_answers[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit in_hold;
  bit no_gaps;

  lru_timestamp_context_cache dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode), .in_key(in_key),
    .in_now_time(in_now_time), .in_slot_index(in_slot_index),
    .in_payload_handle(in_payload_handle),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
    .out_found_index(out_found_index), .out_insert_index(out_insert_index),
    .out_stored_handle(out_stored_handle), .out_insert_error(out_insert_error),
    .out_evicted(out_evicted), .out_hit_total(out_hit_total),
    .out_miss_total(out_miss_total), .out_purge_total(out_purge_total),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Size in effect: zero acts as one entry, anything above the depth as the depth.
  function automatic int unsigned active_entries();
    if (size_reg == '0) return 1;
    if (size_reg > DEPTH) return DEPTH;
    return size_reg;
  endfunction

  // Applies one request to the shadow table and returns the result it should give.
  function automatic cache_resp_t cache_access(cache_req_t rq);
    cache_resp_t r;
    int unsigned size, limit, cand, i;
    logic [TIME_W-1:0] oldest;
    bit have_cand;
    r = '{default: '0};
    size = active_entries();
    if (rq.mode == MODE_LOOKUP) begin
      limit = (tbl_fill < size) ? tbl_fill : size;
      oldest = rq.now;
      cand = 0;
      have_cand = 1'b0;
      // The oldest entry is tracked only up to the first match.
      for (i = 0; i < limit && !r.hit; i++) begin
        if (tbl_stamp[i] < oldest) begin
          oldest = tbl_stamp[i];
          cand = i;
          have_cand = 1'b1;
        end
        if (tbl_key[i] == rq.key) begin
          r.hit = 1'b1;
          r.found_index = OUT_IDX_W'(i);
        end
      end
      if (r.hit) begin
        r.stored_handle = tbl_handle[r.found_index];
        tbl_reuse[r.found_index] += 1;
        tbl_stamp[r.found_index] = rq.now;
        hits_seen += 1;
      end else if (tbl_fill >= size) begin
        r.insert_index = have_cand ? OUT_IDX_W'(cand) : '0;
      end else begin
        r.insert_index = OUT_IDX_W'(tbl_fill);
      end
    end else if (rq.slot >= size) begin
      r.insert_error = 1'b1;
    end else begin
      misses_seen += 1;
      tbl_key[rq.slot] = rq.key;
      tbl_handle[rq.slot] = rq.handle;
      tbl_stamp[rq.slot] = rq.now;
      tbl_reuse[rq.slot] = '0;
      if (rq.slot == tbl_fill && tbl_fill < size) begin
        tbl_fill += 1;
      end else begin
        purges_seen += 1;
        r.evicted = 1'b1;
      end
    end
    r.hit_total = hits_seen;
    r.miss_total = misses_seen;
    r.purge_total = purges_seen;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %0h, expected %0h (t=%0t)", what, got, want, $time);
    mismatches++;
  endtask

  // Most gaps are short, a few are long; none while a burst is running.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Presents one request, waits for its handshake, and records its predicted result.
  task automatic send_request(input logic mode, input logic [KEY_W-1:0] key,
                              input logic [TIME_W-1:0] now, input logic [SLOT_W-1:0] slot,
                              input logic [HANDLE_W-1:0] handle, output cache_resp_t want);
    cache_req_t rq;
    int unsigned gap;
    rq = '{mode, key, now, slot, handle};
    in_valid <= 1'b1;
    in_mode <= mode;
    in_key <= key;
    in_now_time <= now;
    in_slot_index <= slot;
    in_payload_handle <= handle;
    do @(posedge clk); while (!in_ready);
    want = cache_access(rq);
    pending_answers.push_back(want);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      in_hold = 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      in_hold = 1'b1;
    end
  endtask

  // Drops valid if the last request left it up, then waits for every result.
  task automatic drain_requests();
    if (in_hold) begin
      in_valid <= 1'b0;
      in_hold = 1'b0;
    end
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Writes the size register while the block is idle, then reads it back.
  task automatic set_table_size(input logic [TABLE_SIZE_W-1:0] size);
    logic [CFG_DATA_W-1:0] noise;
    drain_requests();
    repeat (SETTLE_CYCLES) @(posedge clk);
    noise = $urandom;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TABLE_SIZE_ADDR;
    pwdata <= {noise[CFG_DATA_W-1:TABLE_SIZE_W], size};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    size_reg = size;
    // Read phase follows directly; psel stays high.
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DATA_W'(size)) report_mismatch("prdata", prdata, size);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Empty table, append, hit, insert past the fill count, and bad slots.
  task automatic test_directed_lookup_insert();
    cache_resp_t r;
    send_request(MODE_LOOKUP, '0, '0, '0, '0, r);
    send_request(MODE_INSERT, '0, '0, '0, '0, r);
    send_request(MODE_LOOKUP, '0, 32'd1, '0, '0, r);
    send_request(MODE_INSERT, '1, '1, 7'd1, '1, r);
    send_request(MODE_LOOKUP, '1, '1, '1, '1, r);
    send_request(MODE_LOOKUP, 64'h5555_5555_5555_5555, 32'd7, '0, '0, r);
    send_request(MODE_INSERT, 64'hA5A5_0000_FFFF_1234, 32'd3, 7'd5, 32'hCAFE_0001, r);
    send_request(MODE_INSERT, 64'h1, 32'd3, 7'd64, 32'h1, r);
    send_request(MODE_INSERT, 64'h2, 32'd3, 7'd127, 32'h2, r);
    send_request(MODE_INSERT, 64'hB0B0_B0B0_0000_0001, 32'd4, 7'd2, 32'h0BAD_0002, r);
  endtask

  // Full table: oldest-entry choice, no older entry, ties, and fill above size.
  task automatic test_lru_replacement();
    cache_resp_t r;
    set_table_size(7'd2);
    send_request(MODE_LOOKUP, 64'hB0B0_B0B0_0000_0001, 32'd10, '0, '0, r);
    send_request(MODE_LOOKUP, 64'hC, 32'd0, '0, '0, r);
    send_request(MODE_INSERT, 64'hC, 32'd5, 7'd1, 32'h0C0C, r);
    send_request(MODE_LOOKUP, 64'hD, 32'd6, '0, '0, r);
    send_request(MODE_LOOKUP, '0, 32'd20, '0, '0, r);
    send_request(MODE_LOOKUP, 64'hD, 32'd30, '0, '0, r);
    send_request(MODE_INSERT, 64'hD, 32'd30, 7'd2, 32'h0D0D, r);
    send_request(MODE_INSERT, 64'hE, 32'd40, 7'd0, 32'h0E0E, r);
    send_request(MODE_INSERT, 64'hF, 32'd40, 7'd1, 32'h0F0F, r);
    send_request(MODE_LOOKUP, 64'h77, 32'd41, '0, '0, r);
  endtask

  // Size register at zero and above the built depth, then at one.
  task automatic test_size_limits();
    cache_resp_t r;
    set_table_size(7'd0);
    send_request(MODE_INSERT, 64'h99, 32'd45, 7'd1, 32'h99, r);
    send_request(MODE_LOOKUP, 64'hF, 32'd50, '0, '0, r);
    set_table_size(7'd127);
    send_request(MODE_LOOKUP, 64'h88, 32'd60, '0, '0, r);
    send_request(MODE_INSERT, 64'h88, 32'd60, 7'd3, 32'h88, r);
    set_table_size(7'd1);
    send_request(MODE_LOOKUP, 64'hE, 32'd70, '0, '0, r);
  endtask

  // Mostly lookup-then-insert-at-proposed-slot pairs, mixed with stray inserts
  // and lookups of unknown keys at arbitrary times.
  task automatic random_phase(input logic [TABLE_SIZE_W-1:0] size, input int unsigned count);
    cache_resp_t look, ins;
    logic [KEY_W-1:0] key_pool[$];
    logic [KEY_W-1:0] key;
    logic [TIME_W-1:0] clock_now;
    logic [SLOT_W-1:0] slot;
    int unsigned sent, pick, n;
    set_table_size(size);
    for (n = 0; n < 2 * active_entries() + 4; n++) key_pool.push_back({$urandom, $urandom});
    clock_now = ($urandom_range(3) == 0) ? 32'hFFFF_F000 + $urandom_range(2048) : $urandom;
    sent = 0;
    while (sent < count) begin
      if (sent % 40 == 0) no_gaps = ($urandom_range(3) == 0);
      clock_now += $urandom_range(3);
      if ($urandom_range(19) == 0) clock_now = $urandom;
      key = key_pool[$urandom_range(key_pool.size() - 1)];
      pick = $urandom_range(99);
      if (pick < 70) begin
        if ($urandom_range(4) == 0) key = {$urandom, $urandom};
        send_request(MODE_LOOKUP, key, clock_now, SLOT_W'($urandom), $urandom, look);
        sent++;
        if (!look.hit && $urandom_range(6) != 0) begin
          send_request(MODE_INSERT, key, clock_now, SLOT_W'(look.insert_index), $urandom, ins);
          sent++;
        end
      end else if (pick < 85) begin
        slot = ($urandom_range(3) == 0) ? SLOT_W'($urandom_range(127))
                                         : SLOT_W'($urandom_range(active_entries() - 1));
        send_request(MODE_INSERT, key, clock_now, slot, $urandom, ins);
        sent++;
      end else begin
        // Very early times leave no entry older than now.
        send_request(MODE_LOOKUP, {$urandom, $urandom},
                     $urandom_range(1) ? 32'($urandom_range(2)) : 32'($urandom),
                     SLOT_W'($urandom), $urandom, look);
        sent++;
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    random_phase(7'd1, 80);
    random_phase(7'd0, 60);
    random_phase(7'd3, 120);
    random_phase(7'd8, 200);
    random_phase(7'd33, 250);
    random_phase(7'd64, 300);
    random_phase(7'd127, 150);
    random_phase(7'd5, 120);
    random_phase(7'd64, 120);
  endtask

  // Result side: random stalls, mostly short, with occasional long open stretches.
  initial begin
    int unsigned run, stall, r;
    @(posedge clk);
    forever begin
      r = $urandom_range(99);
      run = (r < 70) ? $urandom_range(8, 1) : (r < 90) ? $urandom_range(40, 9)
                                                      : $urandom_range(300, 100);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      r = $urandom_range(99);
      stall = (r < 70) ? $urandom_range(2, 1) : (r < 95) ? $urandom_range(10, 3)
                                                         : $urandom_range(80, 30);
      out_ready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    cache_resp_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_hit, out_found_index, out_insert_index, out_stored_handle,
              out_insert_error, out_evicted, out_hit_total, out_miss_total, out_purge_total};
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result", got.hit_total, '0);
      end else begin
        want = pending_answers.pop_front();
        if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
        if (got.found_index !== want.found_index)
          report_mismatch("found_index", got.found_index, want.found_index);
        if (got.insert_index !== want.insert_index)
          report_mismatch("insert_index", got.insert_index, want.insert_index);
        if (got.stored_handle !== want.stored_handle)
          report_mismatch("stored_handle", got.stored_handle, want.stored_handle);
        if (got.insert_error !== want.insert_error)
          report_mismatch("insert_error", got.insert_error, want.insert_error);
        if (got.evicted !== want.evicted) report_mismatch("evicted", got.evicted, want.evicted);
        if (got.hit_total !== want.hit_total)
          report_mismatch("hit_total", got.hit_total, want.hit_total);
        if (got.miss_total !== want.miss_total)
          report_mismatch("miss_total", got.miss_total, want.miss_total);
        if (got.purge_total !== want.purge_total)
          report_mismatch("purge_total", got.purge_total, want.purge_total);
      end
    end
  end

  // Watchdog: too many cycles in a row without any request, result or register access.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("lru_timestamp_context_cache_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_LOOKUP;
    in_key = '0;
    in_now_time = '0;
    in_slot_index = '0;
    in_payload_handle = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_cycles = 0;
    mismatches = 0;
    in_hold = 1'b0;
    no_gaps = 1'b0;
    tbl_key = '{default: '0};
    tbl_handle = '{default: '0};
    tbl_stamp = '{default: '0};
    tbl_reuse = '{default: '0};
    tbl_fill = 0;
    hits_seen = '0;
    misses_seen = '0;
    purges_seen = '0;
    size_reg = TABLE_SIZE_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_lookup_insert();
    test_lru_replacement();
    test_size_limits();
    test_random_traffic();

    drain_requests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("lru_timestamp_context_cache_tb OK");
    end else begin
      $display("lru_timestamp_context_cache_tb NOT OK");
    end
    $finish;
  end

endmodule
